### rtl/core/lfu_cache_table_unit_macros.svh
// assertion macros shared by the checker of the lfu cache table
`ifndef LFU_CACHE_TABLE_UNIT_MACROS_SVH
`define LFU_CACHE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LFU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lfu_pkg.sv
// types and constants shared by the lfu cache table modules
`default_nettype none

package lfu_pkg;

	localparam int ENTRIES   = 16;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W    = IDX_W;
	localparam int OCC_W     = $clog2(ENTRIES + 1);
	localparam int CAP_W     = 5;
	localparam int CMP_W     = (CAP_W > OCC_W) ? CAP_W : OCC_W;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = 32;
	localparam int CAP_RESET = 16;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
		logic [CNT_W-1:0]  count;
	} entry_t;

	// one scanned entry as it comes back from the memory
	typedef struct packed {
		logic              rd_valid;
		logic [IDX_W-1:0]  idx;
		logic              valid;
		logic [RANK_W-1:0] rank;
	} scan_tap_t;

	// what the scan has found so far
	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [DATA_W-1:0] hit_value;
		logic [CNT_W-1:0]  hit_count;
		logic [RANK_W-1:0] hit_rank;
		logic              vic_have;
		logic [IDX_W-1:0]  vic_idx;
		logic [CNT_W-1:0]  vic_count;
		logic [RANK_W-1:0] vic_rank;
		logic [IDX_W-1:0]  free_idx;
	} scan_res_t;

endpackage

`default_nettype wire

### rtl/core/lfu_scan.sv
// scan accumulator: key match, victim selection and first free slot
`default_nettype none

module lfu_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  lfu_pkg::scan_tap_t         tap,
	input  lfu_pkg::entry_t            rd_entry,
	input  logic [lfu_pkg::DATA_W-1:0] key,
	output lfu_pkg::scan_res_t         res
);
	import lfu_pkg::*;

	scan_res_t res_q;
	logic      free_have_q;
	logic      key_match;
	logic      vic_better;

	assign key_match  = (rd_entry.key == key);
	assign vic_better = !res_q.vic_have || (rd_entry.count < res_q.vic_count) ||
		((rd_entry.count == res_q.vic_count) && (tap.rank > res_q.vic_rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q       <= '0;
			free_have_q <= 1'b0;
		end else if (start) begin
			res_q.hit      <= 1'b0;
			res_q.vic_have <= 1'b0;
			res_q.free_idx <= '0;
			free_have_q    <= 1'b0;
		end else if (tap.rd_valid) begin
			if (tap.valid) begin
				if (key_match && !res_q.hit) begin
					res_q.hit       <= 1'b1;
					res_q.hit_idx   <= tap.idx;
					res_q.hit_value <= rd_entry.value;
					res_q.hit_count <= rd_entry.count;
					res_q.hit_rank  <= tap.rank;
				end
				if (vic_better) begin
					res_q.vic_have  <= 1'b1;
					res_q.vic_idx   <= tap.idx;
					res_q.vic_count <= rd_entry.count;
					res_q.vic_rank  <= tap.rank;
				end
			end else if (!free_have_q) begin
				free_have_q    <= 1'b1;
				res_q.free_idx <= tap.idx;
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

### rtl/core/lfu_cache_table_unit.sv
// lfu cache table: fully associative key-value store, lfu replacement, lru tiebreak
// each accepted word goes through a scan of every entry of the entry memory through its
// single read port, a last-read state that folds in the final entry, then the commit,
// which writes the result register; the input takes no new word until the commit is done;
// a stalled result word holds the commit of the next word
// reset: all entries invalid, occupancy zero, capacity 16; no clearing pass is needed
`default_nettype none

module lfu_cache_table_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [lfu_pkg::CAP_W-1:0]    cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic signed [lfu_pkg::DATA_W-1:0] lookup_key,
	input  logic signed [lfu_pkg::DATA_W-1:0] write_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic signed [lfu_pkg::DATA_W-1:0] read_value
);
	import lfu_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST, ST_COMMIT} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CMP_W-1:0] ENT_CMP  = CMP_W'(ENTRIES);

	// control and captured word
	state_t              state_q;
	logic [CAP_W-1:0]    cap_q;
	logic                cmd_q;
	logic [DATA_W-1:0]   key_q;
	logic [DATA_W-1:0]   wval_q;
	logic [IDX_W-1:0]    scan_idx_q;

	// entry memory: key, value and use count, one port read, one port written
	entry_t              entry_mem [ENTRIES];
	entry_t              rd_entry_s1;
	logic                rd_valid_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	entry_t              mem_wdata;

	// valid bits and recency ranks in flops, updated all at once on commit
	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRIES-1:0]  valid_d;
	logic [RANK_W-1:0]   rank_q [ENTRIES];
	logic [RANK_W-1:0]   rank_d [ENTRIES];
	logic [OCC_W-1:0]    occ_q;

	// result register
	logic                out_valid_q;
	logic                found_q;
	logic [DATA_W-1:0]   read_value_q;

	scan_tap_t           tap;
	scan_res_t           res;

	logic                scan_start;
	logic                do_commit;
	logic                is_put;
	logic [CMP_W-1:0]    cap_eff;
	logic                cap_zero;
	logic                do_touch;
	logic                do_insert;
	logic                evict;
	logic                vic_take;
	logic [IDX_W-1:0]    ins_slot;
	logic [CNT_W-1:0]    new_count;

	// input side is open only between words; the result register decouples the output
	assign in_stall   = (state_q != ST_IDLE);
	assign scan_start = (state_q == ST_IDLE) && in_valid;

	// scan tap: valid and rank of the entry whose memory data arrives this cycle
	assign tap.rd_valid = rd_valid_s1;
	assign tap.idx      = rd_idx_s1;
	assign tap.valid    = valid_q[rd_idx_s1];
	assign tap.rank     = rank_q[rd_idx_s1];

	lfu_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.tap      (tap),
		.rd_entry (rd_entry_s1),
		.key      (key_q),
		.res      (res)
	);

	// commit decision, from the finished scan
	assign cap_eff   = (CMP_W'(cap_q) > ENT_CMP) ? ENT_CMP : CMP_W'(cap_q);
	assign cap_zero  = (cap_eff == '0);
	assign is_put    = (cmd_q == CMD_PUT);
	assign do_commit = (state_q == ST_COMMIT) && !(out_valid_q && out_stall);
	assign do_touch  = res.hit && (!is_put || !cap_zero);
	assign do_insert = is_put && !cap_zero && !res.hit;
	assign evict     = (CMP_W'(occ_q) >= cap_eff);
	assign vic_take  = evict && res.vic_have;
	assign ins_slot  = evict ? (res.vic_have ? res.vic_idx : '0) : res.free_idx;
	// use count saturates at all ones
	assign new_count = (res.hit_count == '1) ? res.hit_count : res.hit_count + 1'b1;

	assign mem_we    = do_commit && (do_touch || do_insert);
	assign mem_waddr = do_touch ? res.hit_idx : ins_slot;
	always_comb begin
		if (do_touch) begin
			mem_wdata.key   = key_q;
			mem_wdata.value = is_put ? wval_q : res.hit_value;
			mem_wdata.count = new_count;
		end else begin
			mem_wdata.key   = key_q;
			mem_wdata.value = wval_q;
			mem_wdata.count = CNT_W'(1);
		end
	end

	// per-entry rank and valid update, independent across entries
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i]  = rank_q[i];
			valid_d[i] = valid_q[i];
			if (do_touch) begin
				// entries more recent than the touched one age by one
				if (valid_q[i] && (rank_q[i] < res.hit_rank)) begin
					rank_d[i] = rank_q[i] + 1'b1;
				end
				if (IDX_W'(i) == res.hit_idx) begin
					rank_d[i] = '0;
				end
			end else if (do_insert) begin
				if (valid_q[i]) begin
					if (vic_take && (IDX_W'(i) == res.vic_idx)) begin
						valid_d[i] = 1'b0;
					end else if (vic_take && (rank_q[i] > res.vic_rank)) begin
						// closes the victim's gap and ages by one: no net change
						rank_d[i] = rank_q[i];
					end else begin
						rank_d[i] = rank_q[i] + 1'b1;
					end
				end
				if (IDX_W'(i) == ins_slot) begin
					valid_d[i] = 1'b1;
					rank_d[i]  = '0;
				end
			end
		end
	end

	// memory: written only in commit, read data used only in scan, so the fsm is the interlock
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_waddr] <= mem_wdata;
		end
		rd_entry_s1 <= entry_mem[scan_idx_q];
	end

	// rank payload needs no reset: only read behind a valid bit
	always_ff @(posedge clk) begin
		if (do_commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	// captured word payload
	always_ff @(posedge clk) begin
		if (scan_start) begin
			cmd_q  <= cmd;
			key_q  <= lookup_key;
			wval_q <= write_value;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RESET);
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// fsm, scan pipeline, table control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_idx_q   <= '0;
			rd_valid_s1  <= 1'b0;
			rd_idx_s1    <= '0;
			valid_q      <= '0;
			occ_q        <= '0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			read_value_q <= '0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			rd_idx_s1   <= scan_idx_q;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						scan_idx_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == LAST_IDX) begin
						state_q <= ST_LAST;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_LAST: begin
					// last entry's data is folded into the scan result this cycle
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (do_commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (do_commit) begin
				valid_q <= valid_d;
				if (do_insert && !vic_take) begin
					occ_q <= occ_q + 1'b1;
				end
			end

			if (do_commit) begin
				out_valid_q  <= 1'b1;
				found_q      <= res.hit;
				read_value_q <= (!is_put && res.hit) ? res.hit_value : '0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign read_value = read_value_q;

endmodule

`default_nettype wire

### rtl/core/lfu_chk.sv
// port-level checker for the lfu cache table, bound to the top level
`default_nettype none
`include "lfu_cache_table_unit_macros.svh"

module lfu_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         found,
	input logic [lfu_pkg::DATA_W-1:0]   read_value
);
	import lfu_pkg::*;

	// a stalled result word holds
	`LFU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(found) && $stable(read_value), "stalled result word changed")

	// one word at a time: the input closes right after an accept
	`LFU_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "input open after accept")

	// a miss never carries a value
	`LFU_ASSERT_SAME(a_miss_zero, out_valid && !found, read_value == '0, "miss with nonzero value")

	// a new result leaves the input open for the next word
	`LFU_ASSERT_SAME(a_open_on_result, $rose(out_valid), !in_stall, "input closed when result arrived")

endmodule

bind lfu_cache_table_unit lfu_chk u_lfu_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.found      (found),
	.read_value (read_value)
);

`default_nettype wire
